>>> rtl/core/cavd_pkg.sv
// Shared types, constants and helpers for the carburetor valve duty controller.
package cavd_pkg;

  // Field widths
  localparam int unsigned RpmW    = 15;
  localparam int unsigned TempW   = 12;
  localparam int unsigned PressW  = 14;
  localparam int unsigned CorrW   = 10;
  localparam int unsigned DutyW   = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRpmLoop  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTempLoop = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVacuum   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCutHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCutLow   = 3'd4;

  // Configuration reset values
  localparam logic [RpmW-1:0]   RstRpmLoop  = 15'd100;
  localparam logic [TempW-1:0]  RstTempLoop = 12'd160;
  localparam logic [PressW-1:0] RstVacuum   = 14'd0;
  localparam logic [RpmW-1:0]   RstCutHigh  = 15'd1900;
  localparam logic [RpmW-1:0]   RstCutLow   = 15'd1600;

  // Fixed control constants
  localparam logic [RpmW-1:0]  IdleRpmLimit = 15'd1100;
  localparam logic [RpmW-1:0]  HighLoadRpm  = 15'd4000;
  localparam logic [CorrW-1:0] RichLimit    = 10'h300;  // -256
  localparam logic [DutyW-1:0] DutyMin  = 6'd16;
  localparam logic [DutyW-1:0] DutyMax  = 6'd48;
  localparam logic [DutyW-1:0] DutyHalf = 6'd32;
  localparam logic [DutyW-1:0] DutyFull = 6'd63;
  localparam logic [DutyW-1:0] DutyOff  = 6'd0;

  typedef struct packed {
    logic [RpmW-1:0]   rpm_loop_thr;
    logic [TempW-1:0]  temp_loop_thr;
    logic [PressW-1:0] vacuum_thr;
    logic [RpmW-1:0]   cutoff_rpm_high;
    logic [RpmW-1:0]   cutoff_rpm_low;
  } cfg_t;

  typedef struct packed {
    logic [CorrW-1:0]  lambda_corr;
    logic              lambda_ready;
    logic              throttle_open;
    logic [PressW-1:0] manifold_press;
    logic [PressW-1:0] atmos_press;
    logic [TempW-1:0]  coolant_temp;
    logic [RpmW-1:0]   rpm_inst;
    logic [RpmW-1:0]   rpm_avg;
  } item_t;

  typedef struct packed {
    logic             clear_lambda;
    logic [DutyW-1:0] power_valve_duty;
    logic [DutyW-1:0] idle_valve_duty;
  } result_t;

  // Clamp a scaled duty into the closed-loop window
  function automatic logic [DutyW-1:0] clamp_duty(input logic [7:0] v);
    logic [DutyW-1:0] r;
    if (v < 8'(DutyMin)) begin
      r = DutyMin;
    end else if (v > 8'(DutyMax)) begin
      r = DutyMax;
    end else begin
      r = v[DutyW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/cavd_cfg_regs.sv
// Configuration register file of the valve duty controller.
module cavd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cavd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cavd_pkg::CfgW-1:0]    cfg_wdata_i,
  output cavd_pkg::cfg_t               cfg_o
);

  cavd_pkg::cfg_t cfg_q;

  // Register writes, decoded by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_loop_thr    <= cavd_pkg::RstRpmLoop;
      cfg_q.temp_loop_thr   <= cavd_pkg::RstTempLoop;
      cfg_q.vacuum_thr      <= cavd_pkg::RstVacuum;
      cfg_q.cutoff_rpm_high <= cavd_pkg::RstCutHigh;
      cfg_q.cutoff_rpm_low  <= cavd_pkg::RstCutLow;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cavd_pkg::CfgRpmLoop:  cfg_q.rpm_loop_thr    <= cfg_wdata_i[cavd_pkg::RpmW-1:0];
        cavd_pkg::CfgTempLoop: cfg_q.temp_loop_thr   <= cfg_wdata_i[cavd_pkg::TempW-1:0];
        cavd_pkg::CfgVacuum:   cfg_q.vacuum_thr      <= cfg_wdata_i[cavd_pkg::PressW-1:0];
        cavd_pkg::CfgCutHigh:  cfg_q.cutoff_rpm_high <= cfg_wdata_i[cavd_pkg::RpmW-1:0];
        cavd_pkg::CfgCutLow:   cfg_q.cutoff_rpm_low  <= cfg_wdata_i[cavd_pkg::RpmW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/cavd_duty_core.sv
// Duty law, cut-off hysteresis and held duty state of the valve controller.
module cavd_duty_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,   // item leaves the input register this cycle
  input  cavd_pkg::item_t   item_i,
  input  cavd_pkg::cfg_t    cfg_i,
  output cavd_pkg::result_t res_o
);

  logic                         cutoff_q, cutoff_d;
  logic [cavd_pkg::DutyW-1:0]   idle_q, idle_d;
  logic [cavd_pkg::DutyW-1:0]   power_q, power_d;
  logic                         clear;

  logic                         temp_ok, vac_ok, closed_loop;
  logic [cavd_pkg::PressW-1:0]  vacuum;
  logic [cavd_pkg::CorrW-1:0]   s;
  logic [cavd_pkg::DutyW-1:0]   lean_duty, rich_duty;
  logic                         not_rich;

  // s = 512 + corr in 0..1023: flipping the sign bit does the offset
  assign s = {~item_i.lambda_corr[cavd_pkg::CorrW-1], item_i.lambda_corr[cavd_pkg::CorrW-2:0]};
  // (32*s)>>9 == s>>4 ; ((32*s)>>8)+16 == (s>>3)+16
  assign lean_duty = cavd_pkg::clamp_duty(8'(s[cavd_pkg::CorrW-1:4]));
  assign rich_duty = cavd_pkg::clamp_duty(8'(s[cavd_pkg::CorrW-1:3]) + 8'(cavd_pkg::DutyMin));
  assign not_rich  = $signed(item_i.lambda_corr) > $signed(cavd_pkg::RichLimit);

  // Closed-loop enable conditions
  assign vacuum  = item_i.atmos_press - item_i.manifold_press;
  assign vac_ok  = (item_i.atmos_press > item_i.manifold_press) && (vacuum > cfg_i.vacuum_thr);
  assign temp_ok = $signed(item_i.coolant_temp) > $signed(cfg_i.temp_loop_thr);
  assign closed_loop = item_i.lambda_ready && temp_ok && vac_ok &&
                       (item_i.rpm_inst < cavd_pkg::HighLoadRpm);

  // Mode selection and duty law
  always_comb begin
    cutoff_d = cutoff_q;
    idle_d   = idle_q;
    power_d  = power_q;
    clear    = 1'b0;
    if (item_i.rpm_avg < cfg_i.rpm_loop_thr) begin
      idle_d  = cavd_pkg::DutyFull;
      power_d = cavd_pkg::DutyFull;
    end else if (closed_loop) begin
      if (item_i.throttle_open && (item_i.rpm_inst > cavd_pkg::IdleRpmLimit)) begin
        if (not_rich) begin
          idle_d  = cavd_pkg::DutyFull;
          power_d = lean_duty;
        end else begin
          idle_d  = rich_duty;
          power_d = cavd_pkg::DutyMin;
        end
      end else if (item_i.throttle_open) begin
        idle_d  = lean_duty;
        power_d = cavd_pkg::DutyHalf;
      end else if (!cutoff_q) begin
        // entering cut-off is a transition tick: duties hold
        if (item_i.rpm_inst > cfg_i.cutoff_rpm_high) begin
          cutoff_d = 1'b1;
        end else begin
          idle_d  = lean_duty;
          power_d = cavd_pkg::DutyHalf;
        end
      end else begin
        // leaving cut-off is a transition tick as well
        if (item_i.rpm_inst < cfg_i.cutoff_rpm_low) begin
          cutoff_d = 1'b0;
        end else begin
          clear   = 1'b1;
          idle_d  = cavd_pkg::DutyOff;
          power_d = cavd_pkg::DutyHalf;
        end
      end
    end else begin
      clear   = 1'b1;
      idle_d  = cavd_pkg::DutyHalf;
      power_d = cavd_pkg::DutyHalf;
    end
  end

  // State update when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 1'b0;
      idle_q   <= cavd_pkg::DutyFull;
      power_q  <= cavd_pkg::DutyFull;
    end else if (step_i) begin
      cutoff_q <= cutoff_d;
      idle_q   <= idle_d;
      power_q  <= power_d;
    end
  end

  assign res_o.idle_valve_duty  = idle_d;
  assign res_o.power_valve_duty = power_d;
  assign res_o.clear_lambda     = clear;

  a_cutoff_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cutoff_q))
    else $error("cut-off state changed without an item");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_q == cavd_pkg::DutyFull ||
    (power_q >= cavd_pkg::DutyMin && power_q <= cavd_pkg::DutyMax))
    else $error("power duty out of its legal set");

  a_idle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q == cavd_pkg::DutyFull || idle_q == cavd_pkg::DutyOff ||
    (idle_q >= cavd_pkg::DutyMin && idle_q <= cavd_pkg::DutyMax))
    else $error("idle duty out of its legal set");

endmodule

>>> rtl/core/carb_afr_valve_duty_control.sv
// Top level of the carburetor valve duty controller: input and result registers.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | s_axis_tdata[87:0], one control tick
//  m_axis   | out | m_axis_tvalid / m_axis_tready | m_axis_tdata[15:0], valve duties
//  cfg      | in  | cfg_we_i (always taken)       | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while m_axis is not stalled; a taken word passes
// from the input register through the duty logic into the result register.
// The cut-off and held duty state update as a word moves into the result
// register. Reset clears both registers' valid flags and loads the configuration defaults.
// A stall on m_axis holds the result; the input register takes one more word only
// if it is empty, then s_axis_tready drops until the result is taken.
module carb_afr_valve_duty_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // rpm_avg[14:0] rpm_inst[29:15] coolant_temp[41:30] atmos_press[55:42]
  // manifold_press[69:56] throttle_open[70] lambda_ready[71] lambda_corr[81:72], zero pad
  input  logic [cavd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // idle_valve_duty[5:0] power_valve_duty[11:6] clear_lambda[12], zero pad
  output logic [cavd_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [cavd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cavd_pkg::CfgW-1:0]     cfg_wdata_i
);

  cavd_pkg::cfg_t    cfg;
  cavd_pkg::item_t   item_q;
  cavd_pkg::result_t res, res_q;
  logic              in_valid_q, out_valid_q;
  logic              step, out_free;

  cavd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Pipeline flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= s_axis_tdata[$bits(cavd_pkg::item_t)-1:0];
    end
  end

  cavd_duty_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cavd_pkg::OutDataW'(res_q);

  a_clear_half_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.clear_lambda |-> res_q.power_valve_duty == cavd_pkg::DutyHalf)
    else $error("lambda clear without half power duty");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled while a register is empty");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("word taken by the duty logic did not reach the result register");

endmodule

>>> verif/carb_afr_valve_duty_control_tb.sv
// Self-checking testbench for the carburetor valve duty controller: directed, sweep and random ticks.
module carb_afr_valve_duty_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // rpm_avg, rpm_inst, coolant_temp, atmos_press, manifold_press, throttle_open,
  // lambda_ready, lambda_corr, zero pad
  logic [cavd_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // idle_valve_duty, power_valve_duty, clear_lambda, zero pad
  logic [cavd_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i;
  logic [cavd_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [cavd_pkg::CfgW-1:0]     cfg_wdata_i;

  // Predictor copy of settings and control state
  cavd_pkg::cfg_t             valve_cfg;
  logic                       in_cutoff;
  logic [cavd_pkg::DutyW-1:0] held_idle;
  logic [cavd_pkg::DutyW-1:0] held_power;

  cavd_pkg::result_t expected_duties_q[$];
  int      fail_count;
  bit      src_gaps_on;
  bit      sink_gaps_on;
  int      sink_stall_left;
  int      sink_hold_left;

  carb_afr_valve_duty_control i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5ms;
    $display("FAIL carb_afr_valve_duty_control");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Duty predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_valve_model();
    valve_cfg  = '{cavd_pkg::RstRpmLoop, cavd_pkg::RstTempLoop, cavd_pkg::RstVacuum,
                   cavd_pkg::RstCutHigh, cavd_pkg::RstCutLow};
    in_cutoff  = 1'b0;
    held_idle  = cavd_pkg::DutyFull;
    held_power = cavd_pkg::DutyFull;
  endfunction

  function automatic logic [cavd_pkg::DutyW-1:0] limit_duty(int v);
    if (v < int'(cavd_pkg::DutyMin)) return cavd_pkg::DutyMin;
    if (v > int'(cavd_pkg::DutyMax)) return cavd_pkg::DutyMax;
    return cavd_pkg::DutyW'(v);
  endfunction

  // Closed-loop duty laws; drive_law picks the throttle-open driving law
  function automatic void apply_loop_law(bit drive_law, int corr);
    int s;
    s = 512 + corr;
    if (drive_law) begin
      if (corr > int'($signed(cavd_pkg::RichLimit))) begin
        held_idle  = cavd_pkg::DutyFull;
        held_power = limit_duty((int'(cavd_pkg::DutyHalf) * s) >> 9);
      end else begin
        held_idle  = limit_duty(((int'(cavd_pkg::DutyHalf) * s) >> 8) +
                                int'(cavd_pkg::DutyMin));
        held_power = cavd_pkg::DutyMin;
      end
    end else begin
      held_idle  = limit_duty((int'(cavd_pkg::DutyHalf) * s) >> 9);
      held_power = cavd_pkg::DutyHalf;
    end
  endfunction

  function automatic cavd_pkg::result_t predict_duties(cavd_pkg::item_t t);
    cavd_pkg::result_t r;
    int      vac;
    int      corr;
    logic    clr;
    vac  = int'(t.atmos_press) - int'(t.manifold_press);
    corr = int'($signed(t.lambda_corr));
    clr  = 1'b0;
    if (vac < 0) vac = 0;
    if (t.rpm_avg < valve_cfg.rpm_loop_thr) begin
      held_idle  = cavd_pkg::DutyFull;
      held_power = cavd_pkg::DutyFull;
    end else if (t.lambda_ready &&
                 int'($signed(t.coolant_temp)) > int'($signed(valve_cfg.temp_loop_thr)) &&
                 t.rpm_inst < cavd_pkg::HighLoadRpm && vac > int'(valve_cfg.vacuum_thr)) begin
      if (t.throttle_open) begin
        apply_loop_law(t.rpm_inst > cavd_pkg::IdleRpmLimit, corr);
      end else if (!in_cutoff) begin
        // transition tick into cut-off keeps the held duties
        if (t.rpm_inst > valve_cfg.cutoff_rpm_high) in_cutoff = 1'b1;
        else apply_loop_law(1'b0, corr);
      end else begin
        if (t.rpm_inst < valve_cfg.cutoff_rpm_low) begin
          in_cutoff = 1'b0;
        end else begin
          clr        = 1'b1;
          held_idle  = cavd_pkg::DutyOff;
          held_power = cavd_pkg::DutyHalf;
        end
      end
    end else begin
      // open loop
      clr        = 1'b1;
      held_idle  = cavd_pkg::DutyHalf;
      held_power = cavd_pkg::DutyHalf;
    end
    r.idle_valve_duty  = held_idle;
    r.power_valve_duty = held_power;
    r.clear_lambda     = clr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick builders
  // ---------------------------------------------------------------------------
  function automatic cavd_pkg::item_t make_tick(int avg, int inst, int temp, int atmos,
                                                int man, bit thr_open, bit rdy, int corr);
    cavd_pkg::item_t t;
    t.rpm_avg        = cavd_pkg::RpmW'(avg);
    t.rpm_inst       = cavd_pkg::RpmW'(inst);
    t.coolant_temp   = cavd_pkg::TempW'(temp);
    t.atmos_press    = cavd_pkg::PressW'(atmos);
    t.manifold_press = cavd_pkg::PressW'(man);
    t.throttle_open  = thr_open;
    t.lambda_ready   = rdy;
    t.lambda_corr    = cavd_pkg::CorrW'(corr);
    return t;
  endfunction

  // Mostly ticks that pass the closed-loop gate, some with one gate broken, some noise
  function automatic cavd_pkg::item_t random_tick();
    cavd_pkg::item_t t;
    int    mode;
    int    inst;
    int    tthr;
    int    vthr;
    int    rthr;
    int    vac;
    int    atmos;
    mode = $urandom_range(19, 0);
    tthr = int'($signed(valve_cfg.temp_loop_thr));
    vthr = int'(valve_cfg.vacuum_thr);
    rthr = int'(valve_cfg.rpm_loop_thr);
    if (mode < 3) begin
      t = make_tick($urandom_range(20000, 0), $urandom_range(20000, 0), $urandom, $urandom,
                    $urandom, $urandom_range(1, 0), $urandom_range(1, 0), $urandom);
      return t;
    end
    case ($urandom_range(3, 0))
      0:       inst = int'(valve_cfg.cutoff_rpm_high) + $urandom_range(6, 0) - 3;
      1:       inst = int'(valve_cfg.cutoff_rpm_low) + $urandom_range(6, 0) - 3;
      default: inst = $urandom_range(3999, 0);
    endcase
    if (inst < 0) inst = 0;
    if (inst > 20000) inst = 20000;
    t = make_tick((rthr <= 20000) ? $urandom_range(20000, rthr) : 20000, inst,
                  (tthr < 2047) ? tthr + 1 + $urandom_range(2046 - tthr, 0) : $urandom,
                  $urandom, $urandom, $urandom_range(1, 0), 1'b1, $urandom);
    if (vthr < 16383) begin
      vac   = vthr + 1 + $urandom_range(16382 - vthr, 0);
      atmos = vac + $urandom_range(16383 - vac, 0);
      t.atmos_press    = cavd_pkg::PressW'(atmos);
      t.manifold_press = cavd_pkg::PressW'(atmos - vac);
    end
    if (mode < 6) begin
      case ($urandom_range(4, 0))
        0: t.lambda_ready = 1'b0;
        1: t.coolant_temp = cavd_pkg::TempW'(tthr - int'($urandom_range(tthr + 2048, 0)));
        2: t.rpm_inst = cavd_pkg::RpmW'(int'(cavd_pkg::HighLoadRpm) +
                                        $urandom_range(16000, 0));
        3: t.manifold_press = cavd_pkg::PressW'($urandom_range(16383, int'(t.atmos_press)));
        default: if (rthr > 0) t.rpm_avg = cavd_pkg::RpmW'($urandom_range(rthr - 1, 0));
      endcase
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  task automatic send_tick(input cavd_pkg::item_t t);
    int gap;
    gap = src_gaps_on ? $urandom_range(12, 0) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = cavd_pkg::InDataW'(t);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_duties_q.push_back(predict_duties(t));
  endtask

  // Drop valid and let every outstanding word come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_duties_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [cavd_pkg::CfgIdxW-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i  = 1'b1;
    cfg_idx_i = idx;
    case (idx)
      cavd_pkg::CfgRpmLoop: begin
        valve_cfg.rpm_loop_thr = cavd_pkg::RpmW'(value);
        cfg_wdata_i = cavd_pkg::CfgW'(valve_cfg.rpm_loop_thr);
      end
      cavd_pkg::CfgTempLoop: begin
        valve_cfg.temp_loop_thr = cavd_pkg::TempW'(value);
        cfg_wdata_i = cavd_pkg::CfgW'(valve_cfg.temp_loop_thr);
      end
      cavd_pkg::CfgVacuum: begin
        valve_cfg.vacuum_thr = cavd_pkg::PressW'(value);
        cfg_wdata_i = cavd_pkg::CfgW'(valve_cfg.vacuum_thr);
      end
      cavd_pkg::CfgCutHigh: begin
        valve_cfg.cutoff_rpm_high = cavd_pkg::RpmW'(value);
        cfg_wdata_i = cavd_pkg::CfgW'(valve_cfg.cutoff_rpm_high);
      end
      default: begin
        valve_cfg.cutoff_rpm_low = cavd_pkg::RpmW'(value);
        cfg_wdata_i = cavd_pkg::CfgW'(valve_cfg.cutoff_rpm_low);
      end
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_settings(int rpm_loop, int temp, int vac, int cut_hi, int cut_lo);
    write_setting(cavd_pkg::CfgRpmLoop, rpm_loop);
    write_setting(cavd_pkg::CfgTempLoop, temp);
    write_setting(cavd_pkg::CfgVacuum, vac);
    write_setting(cavd_pkg::CfgCutHigh, cut_hi);
    write_setting(cavd_pkg::CfgCutLow, cut_lo);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: per-word stalls plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      m_axis_tready = 1'b0;
      sink_hold_left--;
    end else if (sink_stall_left > 0) begin
      m_axis_tready = 1'b0;
      sink_stall_left--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    cavd_pkg::result_t got;
    cavd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(cavd_pkg::result_t)-1:0];
      sink_stall_left = sink_gaps_on ? $urandom_range(12, 0) : 0;
      if (expected_duties_q.size() == 0) begin
        note_failure($sformatf("word with nothing expected, tdata=%h", m_axis_tdata));
      end else begin
        want = expected_duties_q.pop_front();
        if (got.idle_valve_duty != want.idle_valve_duty)
          note_failure($sformatf("idle_valve_duty exp %0d got %0d",
                                 want.idle_valve_duty, got.idle_valve_duty));
        if (got.power_valve_duty != want.power_valve_duty)
          note_failure($sformatf("power_valve_duty exp %0d got %0d",
                                 want.power_valve_duty, got.power_valve_duty));
        if (got.clear_lambda != want.clear_lambda)
          note_failure($sformatf("clear_lambda exp %0d got %0d",
                                 want.clear_lambda, got.clear_lambda));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Gate boundaries, duty laws and the cut-off hysteresis under reset settings
  task automatic test_directed_cases();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    send_tick(make_tick(50, 800, 200, 10000, 3000, 0, 1, 0));       // low averaged rpm
    send_tick(make_tick(99, 800, 200, 10000, 3000, 1, 1, 0));
    send_tick(make_tick(100, 1000, 200, 10000, 3000, 1, 1, 0));     // avg at threshold
    send_tick(make_tick(2000, 1500, 200, 10000, 3000, 1, 0, 0));    // lambda not ready
    send_tick(make_tick(2000, 1500, 160, 10000, 3000, 1, 1, 0));    // coolant at threshold
    send_tick(make_tick(2000, 1500, -2048, 10000, 3000, 1, 1, 0));
    send_tick(make_tick(2000, 4000, 200, 10000, 3000, 1, 1, 0));    // high load
    send_tick(make_tick(2000, 3999, 200, 10000, 3000, 1, 1, 511));
    send_tick(make_tick(2000, 1500, 200, 3000, 10000, 1, 1, 0));    // vacuum floored
    send_tick(make_tick(2000, 1500, 200, 3001, 3000, 1, 1, 0));
    send_tick(make_tick(2000, 1101, 200, 10000, 3000, 1, 1, -255));
    send_tick(make_tick(2000, 1101, 200, 10000, 3000, 1, 1, -256)); // rich side
    send_tick(make_tick(2000, 1101, 200, 10000, 3000, 1, 1, -512));
    send_tick(make_tick(2000, 1100, 200, 10000, 3000, 1, 1, 0));    // open idle law
    send_tick(make_tick(2000, 1900, 200, 10000, 3000, 0, 1, 100));  // closed, no cut-off
    send_tick(make_tick(2000, 1901, 200, 10000, 3000, 0, 1, 100));  // enter cut-off
    send_tick(make_tick(2000, 1600, 200, 10000, 3000, 0, 1, 100));  // idle valve off
    send_tick(make_tick(2000, 2000, 200, 10000, 3000, 1, 1, 300));  // open inside cut-off
    send_tick(make_tick(20, 2000, 200, 10000, 3000, 0, 1, 0));      // low avg keeps state
    send_tick(make_tick(2000, 1599, 200, 10000, 3000, 0, 1, 0));    // leave cut-off
    send_tick(make_tick(2000, 800, 200, 10000, 3000, 0, 1, -100));
    send_tick(make_tick(20000, 0, 2047, 16383, 0, 0, 1, 511));
    send_tick(make_tick(20000, 20000, 2047, 16383, 0, 1, 1, -512));
    wait_results_drained();
  endtask

  // Extreme, mid-range and reset register settings, each with a batch of random ticks
  task automatic test_config_sweep();
    int n;
    load_settings(0, -2048, 0, 0, 20000);
    for (n = 0; n < 40; n++) send_tick(random_tick());
    wait_results_drained();
    load_settings(20000, 2047, 16383, 20000, 0);
    for (n = 0; n < 40; n++) send_tick(random_tick());
    wait_results_drained();
    load_settings(1500, -100, 5000, 2500, 2200);
    for (n = 0; n < 40; n++) send_tick(random_tick());
    wait_results_drained();
    load_settings(int'(cavd_pkg::RstRpmLoop), int'($signed(cavd_pkg::RstTempLoop)),
                  int'(cavd_pkg::RstVacuum), int'(cavd_pkg::RstCutHigh),
                  int'(cavd_pkg::RstCutLow));
    for (n = 0; n < 40; n++) send_tick(random_tick());
    wait_results_drained();
  endtask

  // Long sink hold-off while the source keeps offering, then traffic with gaps on both sides
  task automatic test_backpressure();
    int n;
    src_gaps_on    = 1'b0;
    sink_gaps_on   = 1'b0;
    sink_hold_left = 150;
    for (n = 0; n < 30; n++) send_tick(random_tick());
    wait_results_drained();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    for (n = 0; n < 20; n++) send_tick(random_tick());
    wait_results_drained();
  endtask

  // Random settings per phase, random traffic with mixed idling
  task automatic test_random_traffic();
    int phase;
    int n;
    int cut_hi;
    for (phase = 0; phase < 7; phase++) begin
      cut_hi = $urandom_range(3900, 500);
      write_setting(cavd_pkg::CfgRpmLoop, ($urandom_range(3, 0) == 0) ?
                                          $urandom_range(20000, 0) :
                                          $urandom_range(1500, 0));
      write_setting(cavd_pkg::CfgTempLoop, int'($urandom_range(600, 0)) - 300);
      write_setting(cavd_pkg::CfgVacuum, $urandom_range(8000, 0));
      write_setting(cavd_pkg::CfgCutHigh, cut_hi);
      write_setting(cavd_pkg::CfgCutLow, ($urandom_range(4, 0) == 0) ?
                                         $urandom_range(3900, 0) :
                                         $urandom_range(cut_hi, 0));
      src_gaps_on  = ($urandom_range(2, 0) != 0);
      sink_gaps_on = ($urandom_range(2, 0) != 0);
      for (n = 0; n < 70; n++) send_tick(random_tick());
      wait_results_drained();
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = cavd_pkg::CfgRpmLoop;
    cfg_wdata_i     = '0;
    fail_count      = 0;
    src_gaps_on     = 1'b0;
    sink_gaps_on    = 1'b0;
    sink_stall_left = 0;
    sink_hold_left  = 0;
    reset_valve_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    if (fail_count == 0) begin
      $display("PASS carb_afr_valve_duty_control");
    end else begin
      $display("FAIL carb_afr_valve_duty_control");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cavd_pkg.sv
rtl/core/cavd_cfg_regs.sv
rtl/core/cavd_duty_core.sv
rtl/core/carb_afr_valve_duty_control.sv
verif/carb_afr_valve_duty_control_tb.sv
